@@ design/cpl_pkg.sv @@
package cpl_pkg;

  localparam int IDX_W    = 12;   // child index
  localparam int CNT_W    = 13;   // column / row count
  localparam int DV_W     = 14;   // divisor and partial remainder
  localparam int DQ_W     = 61;   // dividend / quotient shift word
  localparam int FRONT_N  = IDX_W;
  localparam int LANE_N   = DQ_W;
  localparam int CORDIC_N = 16;
  localparam int STG_W    = 5;
  localparam int CW       = 34;   // CORDIC datapath width
  localparam int LATENCY  = FRONT_N + LANE_N + CORDIC_N + 5;

  localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [31:0]   ONE_Q30  = 32'sd1073741824;

  localparam logic [2:0] CFG_MODE   = 3'd0;
  localparam logic [2:0] CFG_RADIUS = 3'd1;
  localparam logic [2:0] CFG_START  = 3'd2;
  localparam logic [2:0] CFG_STOP   = 3'd3;
  localparam logic [2:0] CFG_COLS   = 3'd4;
  localparam logic [2:0] CFG_ROWS   = 3'd5;

  localparam logic MODE_CIRCLE = 1'b0;
  localparam logic MODE_GRID   = 1'b1;

  // per-item sideband that rides along the pipeline
  typedef struct packed {
    logic        vld;
    logic [31:0] bx;
    logic [31:0] by;
    logic [11:0] idx;
    logic        negx;
    logic        negy;
    logic [32:0] gqx;
    logic [32:0] gqy;
    logic [1:0]  quad;
  } ctx_t;

  // atan(2^-i) in turns, 32 fraction bits
  function automatic logic [31:0] atan_turn(input logic [STG_W-1:0] i);
    logic [31:0] a;
    unique case (i)
      5'd0:    a = 32'h2000_0000;
      5'd1:    a = 32'h12E4_051E;
      5'd2:    a = 32'h09FB_385B;
      5'd3:    a = 32'h0511_11D4;
      5'd4:    a = 32'h028B_0D43;
      5'd5:    a = 32'h0145_D7E1;
      5'd6:    a = 32'h00A2_F61E;
      5'd7:    a = 32'h0051_7C55;
      5'd8:    a = 32'h0028_BE53;
      5'd9:    a = 32'h0014_5F2F;
      5'd10:   a = 32'h000A_2F98;
      5'd11:   a = 32'h0005_17CC;
      5'd12:   a = 32'h0002_8BE6;
      5'd13:   a = 32'h0001_45F3;
      5'd14:   a = 32'h0000_A2FA;
      5'd15:   a = 32'h0000_517D;
      5'd16:   a = 32'h0000_28BE;
      5'd17:   a = 32'h0000_145F;
      5'd18:   a = 32'h0000_0A30;
      5'd19:   a = 32'h0000_0518;
      5'd20:   a = 32'h0000_028C;
      5'd21:   a = 32'h0000_0146;
      5'd22:   a = 32'h0000_00A3;
      5'd23:   a = 32'h0000_0051;
      default: a = 32'h0000_0000;
    endcase
    return a;
  endfunction

endpackage

@@ design/child_position_layout_unit.sv @@
// Child position layout: base position plus circle-arc or grid offset.
// Pipeline: 12 index-divide cells, 1 multiply, 61 long-divide cells, 1 phase,
//   16 CORDIC cells, 3 output registers.
// Throughput: one item per cycle; busy is never raised and results cannot stall.
// Reset (rst_n low, synchronous) loads register defaults and drops every
//   item in flight.
module child_position_layout_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_base_x,
  input  logic [31:0] in_base_y,
  input  logic [11:0] in_child_index,
  output logic        out_valid,
  output logic [31:0] out_place_x,
  output logic [31:0] out_place_y,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int FN = cpl_pkg::FRONT_N;
  localparam int LN = cpl_pkg::LANE_N;
  localparam int CN = cpl_pkg::CORDIC_N;
  localparam int DQ = cpl_pkg::DQ_W;
  localparam int DV = cpl_pkg::DV_W;
  localparam int CW = cpl_pkg::CW;

  // ---------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------
  logic        mode_r;
  logic [31:0] radius_r, arc_start_r, arc_stop_r;
  logic [12:0] cols_r, rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= cpl_pkg::MODE_CIRCLE;
      radius_r    <= 32'h0001_0000;
      arc_start_r <= 32'h0000_0000;
      arc_stop_r  <= 32'h0001_0000;
      cols_r      <= 13'd1;
      rows_r      <= 13'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cpl_pkg::CFG_MODE:   mode_r      <= cfg_wdata[0];
        cpl_pkg::CFG_RADIUS: radius_r    <= cfg_wdata;
        cpl_pkg::CFG_START:  arc_start_r <= cfg_wdata;
        cpl_pkg::CFG_STOP:   arc_stop_r  <= cfg_wdata;
        cpl_pkg::CFG_COLS:   cols_r      <= cfg_wdata[12:0];
        cpl_pkg::CFG_ROWS:   rows_r      <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  // zero count means one
  logic [12:0]   cols_eff, rows_eff;
  logic          grid;
  logic [DV-1:0] dvs_f, dvs_x, dvs_y;

  assign cols_eff = (cols_r == 13'd0) ? 13'd1 : cols_r;
  assign rows_eff = (rows_r == 13'd0) ? 13'd1 : rows_r;
  assign grid     = (mode_r == cpl_pkg::MODE_GRID);
  assign dvs_f    = {1'b0, cols_eff};
  // grid rounding divides (2*mag + n) by 2n
  assign dvs_x    = grid ? {cols_eff, 1'b0} : {1'b0, cols_eff};
  assign dvs_y    = {rows_eff, 1'b0};

  assign busy = 1'b0;

  // ---------------------------------------------------------------
  // front: child_index / columns, one quotient bit per cell
  // ---------------------------------------------------------------
  cpl_pkg::ctx_t in_ctx;

  always_comb begin
    in_ctx     = '0;
    in_ctx.vld = start && !busy;
    in_ctx.bx  = in_base_x;
    in_ctx.by  = in_base_y;
    in_ctx.idx = in_child_index;
  end

  cpl_pkg::ctx_t f_ctx_r [0:FN-1];
  logic [DV-1:0] f_rem_r [0:FN-1];
  logic [DQ-1:0] f_dq_r  [0:FN-1];

  for (genvar gi = 0; gi < FN; gi++) begin : g_front
    if (gi == 0) begin : g_first
      cpl_div_cell u_cell (
        .clk   (clk),
        .rem_i ('0),
        .dq_i  ({in_child_index, {(DQ-cpl_pkg::IDX_W){1'b0}}}),
        .dvs_i (dvs_f),
        .rem_r (f_rem_r[gi]),
        .dq_r  (f_dq_r[gi])
      );
      always_ff @(posedge clk) begin
        if (!rst_n) f_ctx_r[gi] <= '0;
        else        f_ctx_r[gi] <= in_ctx;
      end
    end else begin : g_next
      cpl_div_cell u_cell (
        .clk   (clk),
        .rem_i (f_rem_r[gi-1]),
        .dq_i  (f_dq_r[gi-1]),
        .dvs_i (dvs_f),
        .rem_r (f_rem_r[gi]),
        .dq_r  (f_dq_r[gi])
      );
      always_ff @(posedge clk) begin
        if (!rst_n) f_ctx_r[gi] <= '0;
        else        f_ctx_r[gi] <= f_ctx_r[gi-1];
      end
    end
  end

  // ---------------------------------------------------------------
  // multiply stage: arc numerator, or radius times grid numerators
  // ---------------------------------------------------------------
  logic [12:0]        col;
  logic [11:0]        row;
  logic signed [32:0] span;
  logic signed [45:0] num;
  logic [44:0]        num_mag;
  logic [14:0]        nx, ny;
  logic [14:0]        nx_mag, ny_mag;
  logic [44:0]        magx_nxt, magy_nxt;
  cpl_pkg::ctx_t      m1_ctx_nxt, m1_ctx_r;
  logic [44:0]        m1_magx_r, m1_magy_r;

  always_comb begin
    col  = f_rem_r[FN-1][12:0];
    row  = f_dq_r[FN-1][11:0];
    span = $signed({arc_stop_r[31], arc_stop_r}) - $signed({arc_start_r[31], arc_start_r});
    num  = span * $signed({1'b0, f_ctx_r[FN-1].idx});
    num_mag = num[45] ? 45'(-num) : num[44:0];
    // 2k+1-n
    nx = {1'b0, col, 1'b1} - {2'b00, cols_eff};
    ny = {2'b00, row, 1'b1} - {2'b00, rows_eff};
    nx_mag = nx[14] ? -nx : nx;
    ny_mag = ny[14] ? -ny : ny;
    magx_nxt = grid ? (radius_r * nx_mag[12:0]) : num_mag;
    magy_nxt = radius_r * ny_mag[12:0];
    m1_ctx_nxt      = f_ctx_r[FN-1];
    m1_ctx_nxt.negx = grid ? nx[14] : num[45];
    m1_ctx_nxt.negy = ny[14];
  end

  always_ff @(posedge clk) begin
    m1_magx_r <= magx_nxt;
    m1_magy_r <= magy_nxt;
    if (!rst_n) m1_ctx_r <= '0;
    else        m1_ctx_r <= m1_ctx_nxt;
  end

  // ---------------------------------------------------------------
  // long divide lanes: x carries the phase span (circle) or grid x
  // ---------------------------------------------------------------
  logic [DQ-1:0] lx_dq0, ly_dq0;

  assign lx_dq0 = grid ? ({15'd0, m1_magx_r, 1'b0} + {48'd0, cols_eff})
                       : {m1_magx_r, 16'd0};
  assign ly_dq0 = {15'd0, m1_magy_r, 1'b0} + {48'd0, rows_eff};

  cpl_pkg::ctx_t l_ctx_r  [0:LN-1];
  logic [DV-1:0] lx_rem_r [0:LN-1];
  logic [DQ-1:0] lx_dq_r  [0:LN-1];
  logic [DV-1:0] ly_rem_r [0:LN-1];
  logic [DQ-1:0] ly_dq_r  [0:LN-1];

  for (genvar gi = 0; gi < LN; gi++) begin : g_lane
    if (gi == 0) begin : g_first
      cpl_div_cell u_x (
        .clk (clk), .rem_i ('0), .dq_i (lx_dq0), .dvs_i (dvs_x),
        .rem_r (lx_rem_r[gi]), .dq_r (lx_dq_r[gi])
      );
      cpl_div_cell u_y (
        .clk (clk), .rem_i ('0), .dq_i (ly_dq0), .dvs_i (dvs_y),
        .rem_r (ly_rem_r[gi]), .dq_r (ly_dq_r[gi])
      );
      always_ff @(posedge clk) begin
        if (!rst_n) l_ctx_r[gi] <= '0;
        else        l_ctx_r[gi] <= m1_ctx_r;
      end
    end else begin : g_next
      cpl_div_cell u_x (
        .clk (clk), .rem_i (lx_rem_r[gi-1]), .dq_i (lx_dq_r[gi-1]), .dvs_i (dvs_x),
        .rem_r (lx_rem_r[gi]), .dq_r (lx_dq_r[gi])
      );
      cpl_div_cell u_y (
        .clk (clk), .rem_i (ly_rem_r[gi-1]), .dq_i (ly_dq_r[gi-1]), .dvs_i (dvs_y),
        .rem_r (ly_rem_r[gi]), .dq_r (ly_dq_r[gi])
      );
      always_ff @(posedge clk) begin
        if (!rst_n) l_ctx_r[gi] <= '0;
        else        l_ctx_r[gi] <= l_ctx_r[gi-1];
      end
    end
  end

  // ---------------------------------------------------------------
  // phase stage: turn phase, nearest quarter turn removed
  // ---------------------------------------------------------------
  logic [31:0]   q32, phase, phase_rnd, zq;
  cpl_pkg::ctx_t ph_ctx_nxt, ph_ctx_r;
  logic [31:0]   ph_z_r;

  always_comb begin
    q32       = lx_dq_r[LN-1][31:0];
    phase     = {arc_start_r[15:0], 16'd0} + (l_ctx_r[LN-1].negx ? -q32 : q32);
    phase_rnd = phase + 32'h2000_0000;
    zq        = phase - {phase_rnd[31:30], 30'd0};
    ph_ctx_nxt      = l_ctx_r[LN-1];
    ph_ctx_nxt.quad = phase_rnd[31:30];
    ph_ctx_nxt.gqx  = lx_dq_r[LN-1][32:0];
    // rows past the grid give huge y offsets; clamping keeps the sum saturated
    ph_ctx_nxt.gqy  = (|ly_dq_r[LN-1][DQ-1:33]) ? {33{1'b1}} : ly_dq_r[LN-1][32:0];
  end

  always_ff @(posedge clk) begin
    ph_z_r <= zq;
    if (!rst_n) ph_ctx_r <= '0;
    else        ph_ctx_r <= ph_ctx_nxt;
  end

  // ---------------------------------------------------------------
  // CORDIC rotator, one stage per cell
  // ---------------------------------------------------------------
  cpl_pkg::ctx_t        c_ctx_r [0:CN-1];
  logic signed [CW-1:0] c_x_r [0:CN-1];
  logic signed [CW-1:0] c_y_r [0:CN-1];
  logic signed [CW-1:0] c_z_r [0:CN-1];
  logic signed [CW-1:0] z0;

  assign z0 = $signed({{(CW-32){ph_z_r[31]}}, ph_z_r});

  for (genvar gi = 0; gi < CN; gi++) begin : g_cordic
    if (gi == 0) begin : g_first
      cpl_cordic_cell u_cell (
        .clk (clk), .stage_i (cpl_pkg::STG_W'(gi)),
        .x_i (cpl_pkg::GAIN_Q30), .y_i ('0), .z_i (z0),
        .x_r (c_x_r[gi]), .y_r (c_y_r[gi]), .z_r (c_z_r[gi])
      );
      always_ff @(posedge clk) begin
        if (!rst_n) c_ctx_r[gi] <= '0;
        else        c_ctx_r[gi] <= ph_ctx_r;
      end
    end else begin : g_next
      cpl_cordic_cell u_cell (
        .clk (clk), .stage_i (cpl_pkg::STG_W'(gi)),
        .x_i (c_x_r[gi-1]), .y_i (c_y_r[gi-1]), .z_i (c_z_r[gi-1]),
        .x_r (c_x_r[gi]), .y_r (c_y_r[gi]), .z_r (c_z_r[gi])
      );
      always_ff @(posedge clk) begin
        if (!rst_n) c_ctx_r[gi] <= '0;
        else        c_ctx_r[gi] <= c_ctx_r[gi-1];
      end
    end
  end

  // ---------------------------------------------------------------
  // quadrant fix-up and clamp to [-1, 1]
  // ---------------------------------------------------------------
  logic signed [CW-1:0] cx, cy, rc, rs;
  logic signed [31:0]   c_nxt, s_nxt;
  cpl_pkg::ctx_t        f1_ctx_r;
  logic signed [31:0]   f1_c_r, f1_s_r;

  function automatic logic signed [31:0] clamp_trig(input logic signed [CW-1:0] v);
    logic signed [31:0] res;
    if (v > $signed({{(CW-32){1'b0}}, cpl_pkg::ONE_Q30}))
      res = cpl_pkg::ONE_Q30;
    else if (v < -$signed({{(CW-32){1'b0}}, cpl_pkg::ONE_Q30}))
      res = -cpl_pkg::ONE_Q30;
    else
      res = v[31:0];
    return res;
  endfunction

  always_comb begin
    cx = c_x_r[CN-1];
    cy = c_y_r[CN-1];
    case (c_ctx_r[CN-1].quad)
      2'd0:    begin rc = cx;  rs = cy;  end
      2'd1:    begin rc = -cy; rs = cx;  end
      2'd2:    begin rc = -cx; rs = -cy; end
      default: begin rc = cy;  rs = -cx; end
    endcase
    c_nxt = clamp_trig(rc);
    s_nxt = clamp_trig(rs);
  end

  always_ff @(posedge clk) begin
    f1_c_r <= c_nxt;
    f1_s_r <= s_nxt;
    if (!rst_n) f1_ctx_r <= '0;
    else        f1_ctx_r <= c_ctx_r[CN-1];
  end

  // radius times cos / sin
  cpl_pkg::ctx_t      f2_ctx_r;
  logic signed [64:0] f2_px_r, f2_py_r;

  always_ff @(posedge clk) begin
    f2_px_r <= $signed({1'b0, radius_r}) * f1_c_r;
    f2_py_r <= $signed({1'b0, radius_r}) * f1_s_r;
    if (!rst_n) f2_ctx_r <= '0;
    else        f2_ctx_r <= f1_ctx_r;
  end

  // ---------------------------------------------------------------
  // final sum with saturation
  // ---------------------------------------------------------------
  function automatic logic [31:0] sat32(input logic signed [35:0] v);
    logic [31:0] res;
    if (v > 36'sd2147483647)
      res = 32'h7FFF_FFFF;
    else if (v < -36'sd2147483648)
      res = 32'h8000_0000;
    else
      res = v[31:0];
    return res;
  endfunction

  logic signed [64:0] px_rnd, py_rnd;
  logic signed [34:0] ox, oy;
  logic signed [35:0] sum_x, sum_y;
  logic               out_valid_r;
  logic [31:0]        out_place_x_r, out_place_y_r;

  always_comb begin
    px_rnd = f2_px_r + 65'sd536870912;
    py_rnd = f2_py_r + 65'sd536870912;
    if (grid) begin
      // y falls as the grid row grows: subtract the row offset
      ox = f2_ctx_r.negx ? -$signed({2'b00, f2_ctx_r.gqx}) : $signed({2'b00, f2_ctx_r.gqx});
      oy = f2_ctx_r.negy ? $signed({2'b00, f2_ctx_r.gqy}) : -$signed({2'b00, f2_ctx_r.gqy});
    end else begin
      ox = px_rnd[64:30];
      oy = py_rnd[64:30];
    end
    sum_x = $signed({{4{f2_ctx_r.bx[31]}}, f2_ctx_r.bx}) + $signed({ox[34], ox});
    sum_y = $signed({{4{f2_ctx_r.by[31]}}, f2_ctx_r.by}) + $signed({oy[34], oy});
  end

  always_ff @(posedge clk) begin
    out_place_x_r <= sat32(sum_x);
    out_place_y_r <= sat32(sum_y);
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= f2_ctx_r.vld;
  end

  assign out_valid   = out_valid_r;
  assign out_place_x = out_place_x_r;
  assign out_place_y = out_place_y_r;

  // ---------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(cpl_pkg::LATENCY) out_valid)
    else $error("item did not come out after the fixed latency");

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    f_ctx_r[FN-1].vld |-> (f_rem_r[FN-1] < dvs_f))
    else $error("column remainder not below column count");

  a_z_range: assert property (@(posedge clk) disable iff (!rst_n)
    ph_ctx_r.vld |-> ($signed(ph_z_r) >= -32'sd536870912 &&
                      $signed(ph_z_r) < 32'sd536870912))
    else $error("CORDIC angle outside one eighth turn");

  a_trig_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    f1_ctx_r.vld |-> (f1_c_r <= cpl_pkg::ONE_Q30 && f1_c_r >= -cpl_pkg::ONE_Q30 &&
                      f1_s_r <= cpl_pkg::ONE_Q30 && f1_s_r >= -cpl_pkg::ONE_Q30))
    else $error("cos/sin outside unit range");

endmodule

@@ design/cpl_div_cell.sv @@
// one restoring-division step: shift one dividend bit in, emit one quotient bit
module cpl_div_cell (
  input  logic                       clk,
  input  logic [cpl_pkg::DV_W-1:0]   rem_i,
  input  logic [cpl_pkg::DQ_W-1:0]   dq_i,
  input  logic [cpl_pkg::DV_W-1:0]   dvs_i,
  output logic [cpl_pkg::DV_W-1:0]   rem_r,
  output logic [cpl_pkg::DQ_W-1:0]   dq_r
);

  logic [cpl_pkg::DV_W:0]   trial;
  logic [cpl_pkg::DV_W:0]   diff;
  logic                     ge;
  logic [cpl_pkg::DV_W-1:0] rem_nxt;
  logic [cpl_pkg::DQ_W-1:0] dq_nxt;

  always_comb begin
    trial   = {rem_i, dq_i[cpl_pkg::DQ_W-1]};
    diff    = trial - {1'b0, dvs_i};
    ge      = (trial >= {1'b0, dvs_i});
    rem_nxt = ge ? diff[cpl_pkg::DV_W-1:0] : trial[cpl_pkg::DV_W-1:0];
    dq_nxt  = {dq_i[cpl_pkg::DQ_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
  end

endmodule

@@ design/cpl_cordic_cell.sv @@
// one CORDIC rotation step, floor shifts
module cpl_cordic_cell (
  input  logic                          clk,
  input  logic [cpl_pkg::STG_W-1:0]     stage_i,
  input  logic signed [cpl_pkg::CW-1:0] x_i,
  input  logic signed [cpl_pkg::CW-1:0] y_i,
  input  logic signed [cpl_pkg::CW-1:0] z_i,
  output logic signed [cpl_pkg::CW-1:0] x_r,
  output logic signed [cpl_pkg::CW-1:0] y_r,
  output logic signed [cpl_pkg::CW-1:0] z_r
);

  logic signed [cpl_pkg::CW-1:0] sx, sy, at;
  logic signed [cpl_pkg::CW-1:0] x_nxt, y_nxt, z_nxt;

  always_comb begin
    sx = x_i >>> stage_i;
    sy = y_i >>> stage_i;
    at = $signed({2'b00, cpl_pkg::atan_turn(stage_i)});
    if (!z_i[cpl_pkg::CW-1]) begin
      x_nxt = x_i - sy;
      y_nxt = y_i + sx;
      z_nxt = z_i - at;
    end else begin
      x_nxt = x_i + sy;
      y_nxt = y_i - sx;
      z_nxt = z_i + at;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

endmodule
